// File: hw/rtl/schb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schb_pkg
// Shared types, widths and helpers for the capsule-versus-box hit test.
// ----------------------------------------------------------------------------
package schb_pkg;

    localparam int COORD_W     = 32;            // signed Q16.16 coordinate
    localparam int DIFF_W      = COORD_W + 1;   // difference of two coordinates
    localparam int WIDE_W      = COORD_W + 2;   // coordinate widened by a radius
    localparam int RAD_W       = COORD_W - 1;
    localparam int T_BITS      = 32;            // crossing fraction bits
    localparam int REM_W       = DIFF_W + 1;    // divider remainder
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int NUM_FACES   = 6;
    localparam int FACE_LAT    = T_BITS + 4;    // face unit register stages
    localparam int PIPE_LAST   = FACE_LAT + 1;  // index of the output stage
    localparam int IN_TDATA_W  = 224;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        coord_t [2:0]     p1;
        coord_t [2:0]     p2;
        logic [RAD_W-1:0] rad;
    } seg_t;

    function automatic wide_t widen(input logic [COORD_W-1:0] v);
        return wide_t'($signed(v));
    endfunction

    function automatic wide_t rad_w(input logic [RAD_W-1:0] r);
        return wide_t'({1'b0, r});
    endfunction

    // first and second axis other than the given one
    function automatic logic [1:0] axis_u(input logic [1:0] a);
        logic [1:0] u;
        case (a)
            2'd0:    u = 2'd1;
            default: u = 2'd0;
        endcase
        return u;
    endfunction

    function automatic logic [1:0] axis_v(input logic [1:0] a);
        logic [1:0] v;
        case (a)
            2'd2:    v = 2'd1;
            default: v = 2'd2;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/segment_capsule_box_hit_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_capsule_box_hit_test_unit
// Segment / capsule against axis-aligned box hit test, fully pipelined.
// ----------------------------------------------------------------------------
// Pipeline from input transfer to result on m_axis: input register,
//   36 face-unit stages set by the 32-stage divider for t, output register.
// Throughput: one item per cycle; the whole pipe holds while a result waits.
// Reset: rst_n clears all valid bits and the six box registers to zero.
// ----------------------------------------------------------------------------
module segment_capsule_box_hit_test_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z (32 each), radius (31), pad
    input  logic [schb_pkg::IN_TDATA_W-1:0]         s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // hit (bit 0), pad
    output logic [schb_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    input  logic                                    cfg_we,
    input  logic [schb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [schb_pkg::COORD_W-1:0]            cfg_data
);
    import schb_pkg::*;

    // box registers
    coord_t [2:0] box_min_reg, box_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_reg <= '0;
            box_max_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MIN_X: box_min_reg[0] <= cfg_data;
                REG_MIN_Y: box_min_reg[1] <= cfg_data;
                REG_MIN_Z: box_min_reg[2] <= cfg_data;
                REG_MAX_X: box_max_reg[0] <= cfg_data;
                REG_MAX_Y: box_max_reg[1] <= cfg_data;
                REG_MAX_Z: box_max_reg[2] <= cfg_data;
                default:   ;  // indexes above 5 are dropped
            endcase
        end
    end

    // global advance: every stage moves unless the output holds an untaken result
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic [PIPE_LAST:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[PIPE_LAST-1:0], s_axis_tvalid};
    end

    // input register
    seg_t seg_next, seg_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            seg_next.p1[k] = s_axis_tdata[COORD_W*k +: COORD_W];
            seg_next.p2[k] = s_axis_tdata[COORD_W*(k+3) +: COORD_W];
        end
        seg_next.rad = s_axis_tdata[COORD_W*6 +: RAD_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            seg_reg <= seg_next;
    end

    // quick rejects and start-inside test, then carried alongside the faces
    logic rej_next, ins_next;

    always_comb
    begin
        rej_next = 1'b0;
        ins_next = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            if ((widen(seg_reg.p2[k]) + rad_w(seg_reg.rad) < widen(box_min_reg[k])) &&
                (widen(seg_reg.p1[k]) + rad_w(seg_reg.rad) < widen(box_min_reg[k])))
                rej_next = 1'b1;
            if ((widen(seg_reg.p2[k]) - rad_w(seg_reg.rad) > widen(box_max_reg[k])) &&
                (widen(seg_reg.p1[k]) - rad_w(seg_reg.rad) > widen(box_max_reg[k])))
                rej_next = 1'b1;
            if (($signed(seg_reg.p1[k]) < $signed(box_min_reg[k])) ||
                ($signed(seg_reg.p1[k]) > $signed(box_max_reg[k])))
                ins_next = 1'b0;
        end
    end

    logic [FACE_LAT:1] rej_reg, ins_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rej_reg <= {rej_reg[FACE_LAT-1:1], rej_next};
            ins_reg <= {ins_reg[FACE_LAT-1:1], ins_next};
        end
    end

    // six face units: min x, y, z then max x, y, z
    logic [NUM_FACES-1:0] face_hit;

    for (genvar f = 0; f < NUM_FACES; f++)
    begin : g_face
        schb_face u_face (
            .clk     (clk),
            .en      (en),
            .axis    (2'(f % 3)),
            .plane   ((f < 3) ? box_min_reg[f % 3] : box_max_reg[f % 3]),
            .box_min (box_min_reg),
            .box_max (box_max_reg),
            .seg     (seg_reg),
            .hit     (face_hit[f])
        );
    end

    // output register
    logic hit_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            hit_reg <= !rej_reg[FACE_LAT] && (ins_reg[FACE_LAT] || (|face_hit));
    end

    assign m_axis_tvalid = valid_reg[PIPE_LAST];
    assign m_axis_tdata  = {(OUT_TDATA_W-1)'(0), hit_reg};

    // a stalled pipe keeps every valid bit in place
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("valid line moved during stall");

    // an advancing pipe moves each valid bit one stage on
    a_advance_shifts: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> valid_reg[PIPE_LAST:1] == $past(valid_reg[PIPE_LAST-1:0]))
        else $error("valid line lost or repeated an item");

    // input is taken exactly when the output side can move
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stalled");

endmodule

// File: hw/rtl/schb_face.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schb_face
// One face-plane crossing: sign test, 32-stage restoring divider for t,
// crossing point by multiply, bound check widened by the radius.
// ----------------------------------------------------------------------------
module schb_face (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [1:0]                             axis,
    input  schb_pkg::coord_t                       plane,
    input  schb_pkg::coord_t [2:0]                 box_min,
    input  schb_pkg::coord_t [2:0]                 box_max,
    input  schb_pkg::seg_t                         seg,
    output logic                                   hit
);
    import schb_pkg::*;

    typedef struct packed {
        logic              cand;
        logic              endsel;
        coord_t            p1u;
        coord_t            p1v;
        coord_t            p2u;
        coord_t            p2v;
        logic [DIFF_W-1:0] du;
        logic [DIFF_W-1:0] dv;
        logic [RAD_W-1:0]  rad;
        logic [DIFF_W-1:0] b;
    } ctx_t;

    logic [1:0]               ax_u, ax_v;
    logic signed [DIFF_W-1:0] d1, d2, dd;
    logic                     cand;

    ctx_t             ctx_reg [0:T_BITS];
    logic [REM_W-1:0] r_reg   [0:T_BITS];
    logic [T_BITS-1:0] t_reg  [0:T_BITS];

    assign ax_u = axis_u(axis);
    assign ax_v = axis_v(axis);

    always_comb
    begin
        d1   = DIFF_W'($signed(seg.p1[axis])) - DIFF_W'($signed(plane));
        d2   = DIFF_W'($signed(seg.p2[axis])) - DIFF_W'($signed(plane));
        dd   = DIFF_W'($signed(seg.p2[axis])) - DIFF_W'($signed(seg.p1[axis]));
        cand = !((d1 > 0 && d2 > 0) || (d1 < 0 && d2 < 0)) && (d1 != d2);
    end

    // entry stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0].cand   <= cand;
            ctx_reg[0].endsel <= (d2 == '0);
            ctx_reg[0].p1u    <= seg.p1[ax_u];
            ctx_reg[0].p1v    <= seg.p1[ax_v];
            ctx_reg[0].p2u    <= seg.p2[ax_u];
            ctx_reg[0].p2v    <= seg.p2[ax_v];
            ctx_reg[0].du     <= DIFF_W'($signed(seg.p2[ax_u])) - DIFF_W'($signed(seg.p1[ax_u]));
            ctx_reg[0].dv     <= DIFF_W'($signed(seg.p2[ax_v])) - DIFF_W'($signed(seg.p1[ax_v]));
            ctx_reg[0].rad    <= seg.rad;
            ctx_reg[0].b      <= dd[DIFF_W-1] ? DIFF_W'(-dd) : DIFF_W'(dd);
            r_reg[0]          <= REM_W'(d1[DIFF_W-1] ? DIFF_W'(-d1) : DIFF_W'(d1));
            t_reg[0]          <= '0;
        end
    end

    // divider: one quotient bit per stage
    for (genvar i = 1; i <= T_BITS; i++)
    begin : g_div
        logic [REM_W-1:0] rs;
        logic             ge;
        always_comb
        begin
            rs = {r_reg[i-1][REM_W-2:0], 1'b0};
            ge = (rs >= REM_W'(ctx_reg[i-1].b));
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctx_reg[i] <= ctx_reg[i-1];
                r_reg[i]   <= ge ? rs - REM_W'(ctx_reg[i-1].b) : rs;
                t_reg[i]   <= {t_reg[i-1][T_BITS-2:0], ge};
            end
        end
    end

    // multiply stage
    ctx_t                     ctx_m_reg;
    logic signed [PROD_W-1:0] prod_u_reg, prod_v_reg;
    logic signed [DIFF_W-1:0] t_s;

    assign t_s = $signed({1'b0, t_reg[T_BITS]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_m_reg  <= ctx_reg[T_BITS];
            prod_u_reg <= PROD_W'($signed(ctx_reg[T_BITS].du)) * PROD_W'(t_s);
            prod_v_reg <= PROD_W'($signed(ctx_reg[T_BITS].dv)) * PROD_W'(t_s);
        end
    end

    // crossing point and widened bounds
    logic  cand_p_reg;
    wide_t pt_u_reg, pt_v_reg, lo_u_reg, hi_u_reg, lo_v_reg, hi_v_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cand_p_reg <= ctx_m_reg.cand;
            pt_u_reg   <= ctx_m_reg.endsel ? widen(ctx_m_reg.p2u)
                        : widen(ctx_m_reg.p1u) + wide_t'(prod_u_reg[T_BITS+WIDE_W-1:T_BITS]);
            pt_v_reg   <= ctx_m_reg.endsel ? widen(ctx_m_reg.p2v)
                        : widen(ctx_m_reg.p1v) + wide_t'(prod_v_reg[T_BITS+WIDE_W-1:T_BITS]);
            lo_u_reg   <= widen(box_min[ax_u]) - rad_w(ctx_m_reg.rad);
            hi_u_reg   <= widen(box_max[ax_u]) + rad_w(ctx_m_reg.rad);
            lo_v_reg   <= widen(box_min[ax_v]) - rad_w(ctx_m_reg.rad);
            hi_v_reg   <= widen(box_max[ax_v]) + rad_w(ctx_m_reg.rad);
        end
    end

    logic hit_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= cand_p_reg
                    && (pt_u_reg >= lo_u_reg) && (pt_u_reg <= hi_u_reg)
                    && (pt_v_reg >= lo_v_reg) && (pt_v_reg <= hi_v_reg);
        end
    end

    assign hit = hit_reg;

endmodule

// File: tb/segment_capsule_box_hit_test_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_capsule_box_hit_test_unit_tb
// Self-checking bench for the capsule-versus-box hit test. A directed table
// covers reset state, extremes, faces, touching and parallel cases. Random
// segments are then aimed mostly around the programmed box under several box
// settings. Every hit bit is checked against a typed-in answer or an in-bench
// predictor, and both stream sides idle at random outside the burst phase.
// ----------------------------------------------------------------------------
module segment_capsule_box_hit_test_unit_tb;
    import schb_pkg::*;

    // wide signed type: holds products of a 33-bit delta and a 33-bit fraction
    typedef logic signed [99:0] big_t;

    // one segment query, plus an optional typed-in answer
    typedef struct {
        coord_t           a [3];
        coord_t           b [3];
        logic [RAD_W-1:0] rad;
        bit               known;
        bit               want;
    } query_t;

    localparam int    LAT_WAIT = 45;      // longer than the pipe from input to result
    localparam int    WDOG_MAX = 5000;    // cycles with no transfer at all
    localparam coord_t ONE     = 32'sd65536;
    localparam coord_t TEN     = 32'sd655360;
    localparam coord_t C_MIN   = 32'sh8000_0000;
    localparam coord_t C_MAX   = 32'sh7fff_ffff;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [COORD_W-1:0]     cfg_data = '0;

    // bench copy of the box: lower and upper bounds per axis
    coord_t box_lo [3];
    coord_t box_hi [3];

    bit     hit_q [$];                   // hit bits awaiting their transfer
    query_t rows [$];
    int     errors = 0;
    int     stall_cnt = 0;
    bit     no_idle = 1'b0;              // burst window: neither side idles

    always #5 clk = ~clk;

    segment_capsule_box_hit_test_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // One face plane: crossing point checked against the two other axes,
    // bounds widened by the radius. Equal distances (parallel) never cross.
    function automatic bit face_cross(int ax, big_t plane, query_t q);
        big_t d1;
        big_t d2;
        big_t num;
        big_t den;
        big_t frac;
        big_t r;
        big_t pt [3];
        d1 = big_t'(q.a[ax]) - plane;
        d2 = big_t'(q.b[ax]) - plane;
        r  = big_t'({1'b0, q.rad});
        if ((d1 > 0 && d2 > 0) || (d1 < 0 && d2 < 0))
            return 1'b0;
        if (d1 == d2)
            return 1'b0;
        if (d2 == 0) begin
            // fraction reaches one: crossing is the end point itself
            for (int k = 0; k < 3; k++)
                pt[k] = big_t'(q.b[k]);
        end
        else begin
            num  = (d1 < 0) ? -d1 : d1;
            den  = (d2 > d1) ? d2 - d1 : d1 - d2;
            frac = (num <<< 32) / den;             // 0.32 fraction, truncated
            for (int k = 0; k < 3; k++)
                pt[k] = big_t'(q.a[k])
                      + (((big_t'(q.b[k]) - big_t'(q.a[k])) * frac) >>> 32);
        end
        for (int k = 0; k < 3; k++) begin
            if (k == ax)
                continue;
            if (pt[k] < big_t'(box_lo[k]) - r || pt[k] > big_t'(box_hi[k]) + r)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit capsule_hits(query_t q);
        big_t r;
        bit   start_in;
        r = big_t'({1'b0, q.rad});
        // quick rejects: both ends beyond one widened face
        for (int k = 0; k < 3; k++) begin
            if (big_t'(q.b[k]) + r < big_t'(box_lo[k]) &&
                big_t'(q.a[k]) + r < big_t'(box_lo[k]))
                return 1'b0;
            if (big_t'(q.b[k]) - r > big_t'(box_hi[k]) &&
                big_t'(q.a[k]) - r > big_t'(box_hi[k]))
                return 1'b0;
        end
        // start point inside, inclusive, radius not applied
        start_in = 1'b1;
        for (int k = 0; k < 3; k++)
            if (q.a[k] < box_lo[k] || q.a[k] > box_hi[k])
                start_in = 1'b0;
        if (start_in)
            return 1'b1;
        for (int k = 0; k < 3; k++)
            if (face_cross(k, big_t'(box_lo[k]), q))
                return 1'b1;
        for (int k = 0; k < 3; k++)
            if (face_cross(k, big_t'(box_hi[k]), q))
                return 1'b1;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration and stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, coord_t val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        // indexes above the last box register are dropped by the block
        if (idx <= REG_MAX_Z) begin
            if (idx < REG_MAX_X)
                box_lo[idx] = val;
            else
                box_hi[idx - REG_MAX_X] = val;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_box(coord_t lx, coord_t ly, coord_t lz,
                           coord_t hx, coord_t hy, coord_t hz);
        write_reg(REG_MIN_X, lx);
        write_reg(REG_MIN_Y, ly);
        write_reg(REG_MIN_Z, lz);
        write_reg(REG_MAX_X, hx);
        write_reg(REG_MAX_Y, hy);
        write_reg(REG_MAX_Z, hz);
    endtask

    // box may only change once the pipe is empty; input side goes idle first
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (hit_q.size() != 0)
            @(posedge clk);
        repeat (LAT_WAIT) @(posedge clk);
    endtask

    task automatic add_row(coord_t ax, coord_t ay, coord_t az,
                           coord_t bx, coord_t by, coord_t bz,
                           logic [RAD_W-1:0] rad, bit known, bit want);
        query_t q;
        q.a[0] = ax; q.a[1] = ay; q.a[2] = az;
        q.b[0] = bx; q.b[1] = by; q.b[2] = bz;
        q.rad = rad; q.known = known; q.want = want;
        rows.push_back(q);
    endtask

    // drive one query; returns at the edge where its transfer happened
    task automatic send_query(query_t q);
        bit rdy;
        while (!no_idle && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, q.rad, q.b[2], q.b[1], q.b[0],
                          q.a[2], q.a[1], q.a[0]};
        do begin
            @(negedge clk);
            rdy = s_axis_tready;
            @(posedge clk);
        end while (!rdy);
        hit_q.push_back(q.known ? q.want : capsule_hits(q));
    endtask

    task automatic run_rows();
        while (rows.size() != 0)
            send_query(rows.pop_front());
    endtask

    function automatic coord_t clamp(longint v);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return coord_t'(v);
    endfunction

    // mostly near a box face or centre, some full-range noise
    function automatic coord_t pick_coord(int k);
        longint base;
        longint off;
        case ($urandom_range(9))
            0, 1:    return coord_t'($urandom);
            2:       return $urandom_range(1) ? C_MAX : C_MIN;
            default: begin
                case ($urandom_range(2))
                    0:       base = box_lo[k];
                    1:       base = box_hi[k];
                    default: base = (longint'(box_lo[k]) + longint'(box_hi[k])) / 2;
                endcase
                off = longint'($urandom_range(1 << 21)) - (1 << 20);
                if ($urandom_range(3) == 0)
                    off = off * 64;
                return clamp(base + off);
            end
        endcase
    endfunction

    function automatic logic [RAD_W-1:0] pick_rad();
        case ($urandom_range(9))
            0, 1, 2, 3: return '0;
            4:          return {RAD_W{1'b1}};
            5:          return RAD_W'($urandom);
            default:    return RAD_W'($urandom_range(1 << 19));
        endcase
    endfunction

    task automatic run_random(int n);
        query_t q;
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 3; k++) begin
                q.a[k] = pick_coord(k);
                q.b[k] = pick_coord(k);
            end
            // now and then lay the end on a face plane or make it parallel
            case ($urandom_range(9))
                0: q.b[0] = box_lo[0];
                1: q.b[2] = q.a[2];
                default: ;
            endcase
            q.rad   = pick_rad();
            q.known = 1'b0;
            q.want  = 1'b0;
            send_query(q);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, checking, watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        bit want;
        if (rst_n) begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= 35);
            if (m_axis_tvalid && m_axis_tready) begin
                if (hit_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, hit %0b",
                             $time, m_axis_tdata[0]);
                    errors++;
                end
                else begin
                    want = hit_q.pop_front();
                    if (m_axis_tdata[0] !== want) begin
                        $display("%0t: hit mismatch, expected %0b actual %0b",
                                 $time, want, m_axis_tdata[0]);
                        errors++;
                    end
                end
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= WDOG_MAX) begin
                $display("segment_capsule_box_hit_test_unit_tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int k = 0; k < 3; k++) begin
            box_lo[k] = '0;
            box_hi[k] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset box is the single point at the origin
        add_row(0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1);
        add_row(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 0, 1'b1, 1'b0);
        add_row(-ONE, 0, 0, ONE, 0, 0, 0, 1'b0, 1'b0);
        add_row(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0, 1'b0, 1'b0);
        run_rows();
        drain();

        set_box(-TEN, -TEN, -TEN, TEN, TEN, TEN);
        // through the box along each axis
        add_row(-2 * TEN, 0, 0, 2 * TEN, 0, 0, 0, 1'b0, 1'b0);
        add_row(0, -2 * TEN, 0, 0, 2 * TEN, 0, 0, 1'b0, 1'b0);
        add_row(0, 0, 2 * TEN, 0, 0, -2 * TEN, 0, 1'b0, 1'b0);
        // end point lands exactly on the min x face
        add_row(-2 * TEN, ONE, ONE, -TEN, ONE, ONE, 0, 1'b0, 1'b0);
        // parallel, lying in the max y plane outside in x
        add_row(2 * TEN, TEN, 0, 3 * TEN, TEN, 0, 0, 1'b0, 1'b0);
        // passes beside the box: miss plain, touch with radius
        add_row(-2 * TEN, TEN + ONE, 0, 2 * TEN, TEN + ONE, 0, 0, 1'b0, 1'b0);
        add_row(-2 * TEN, TEN + ONE, 0, 2 * TEN, TEN + ONE, 0, 31'd65536, 1'b0, 1'b0);
        // far both ends, plain: quick reject
        add_row(3 * TEN, 3 * TEN, 3 * TEN, 4 * TEN, 4 * TEN, 4 * TEN, 0, 1'b1, 1'b0);
        // extremes of coordinates and radius
        add_row(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, {RAD_W{1'b1}}, 1'b0, 1'b0);
        add_row(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, {RAD_W{1'b1}}, 1'b0, 1'b0);
        add_row(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 0, 1'b0, 1'b0);
        add_row(C_MAX, 0, 0, C_MIN, 0, 0, 0, 1'b0, 1'b0);
        // start inside, on a corner
        add_row(TEN, TEN, TEN, C_MAX, C_MAX, C_MAX, 0, 1'b1, 1'b1);
        add_row(TEN + 1, TEN, TEN, C_MAX, C_MAX, C_MAX, 0, 1'b0, 1'b0);
        run_rows();
        drain();

        // out-of-range indexes must leave the box alone
        write_reg(3'd6, C_MIN);
        write_reg(3'd7, C_MAX);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: set_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
                1: set_box(TEN, TEN, TEN, -TEN, -TEN, -TEN);     // inverted
                2: set_box(ONE, -ONE, 0, ONE, -ONE, 0);          // zero size
                3: set_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
                4: set_box(-TEN, -2 * TEN, -3 * TEN, TEN, 2 * TEN, 3 * TEN);
                default: begin
                    for (int k = 0; k < 3; k++) begin
                        write_reg(CFG_IDX_W'(k), coord_t'($urandom));
                        write_reg(CFG_IDX_W'(k + 3), clamp(longint'(box_lo[k])
                                  + longint'($urandom_range(1 << 24))));
                    end
                end
            endcase
            no_idle = (ph == 4);
            run_random(100);
            no_idle = 1'b0;
        end

        drain();
        if (errors == 0)
            $display("segment_capsule_box_hit_test_unit_tb: clean");
        else
            $display("segment_capsule_box_hit_test_unit_tb: errors");
        $finish;
    end

endmodule
